@@ hdl/gmtf_pkg.sv @@
package gmtf_pkg;

	// Width of a member ID and of a payload handle.
	localparam int ID_W = 16;

	// Default number of table entries.
	localparam int CAPACITY_DEF = 32;

	// Operation codes carried by the operation field.
	localparam logic OP_MSG   = 1'b0;
	localparam logic OP_LEAVE = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

@@ hdl/group_member_table_fanout.sv @@
// Ordered member table with message fan-out.
// Input channel: an item (operation, sender_id, payload_handle) is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// item is fully handled, so one item is worked on at a time.
// Output channel: each result (receiver_id, origin_id, payload_out, last)
// is shown for exactly one cycle with valid high; the receiver cannot stall.
// The final copy of a message carries last high. A leave item, or a message
// with no other member in the table, gives no result.
// An item keeps busy high through a scan over the table entries present at
// acceptance and a closing step; with an empty table the scan is skipped.
// The next item can be taken once busy has fallen. The table sits in one
// memory with one read and one write port; a single pass reads every entry
// once. Results stream out during the pass; the last one is registered out
// of the closing step and appears once busy is low.
// A leave removes the ID in the same pass by writing each later entry one
// place down; a message appends an absent sender at the end of the pass, if there is room.
// Reset clears the entry count and the sequencer; the memory needs no
// clearing since only entries below the count are ever read.
module group_member_table_fanout #(
	parameter int CAPACITY = gmtf_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      operation,
	input  logic [gmtf_pkg::ID_W-1:0] sender_id,
	input  logic [gmtf_pkg::ID_W-1:0] payload_handle,
	output logic                      valid,
	output logic [gmtf_pkg::ID_W-1:0] receiver_id,
	output logic [gmtf_pkg::ID_W-1:0] origin_id,
	output logic [gmtf_pkg::ID_W-1:0] payload_out,
	output logic                      last
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ID_W  = gmtf_pkg::ID_W;

	logic [ID_W-1:0]       mem [CAPACITY];

	gmtf_pkg::state_t      state_q, state_d;
	logic                  op_q;
	logic [ID_W-1:0]       sender_q;
	logic [ID_W-1:0]       payload_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      iss_q;
	logic                  rvld_s1;
	logic [IDX_W-1:0]      ridx_s1;
	logic [ID_W-1:0]       rd_s1;
	logic                  found_q;
	logic                  pend_vld_q;
	logic [ID_W-1:0]       pend_q;
	logic [CNT_W-1:0]      ncol_q;
	logic                  valid_q;
	logic [ID_W-1:0]       recv_q;
	logic                  last_q;

	logic                  accept;
	logic                  issue;
	logic                  hit;
	logic                  take;
	logic                  scan_end;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [ID_W-1:0]       wdata;
	logic                  emit;
	logic                  emit_last;

	assign accept = start && (state_q == gmtf_pkg::ST_IDLE);

	// Compare the entry read last cycle against the sender.
	assign hit = rvld_s1 && (rd_s1 == sender_q);
	assign take = rvld_s1 && !hit && (op_q == gmtf_pkg::OP_MSG)
		&& (ncol_q < CNT_W'(CAPACITY - 1));
	assign scan_end = rvld_s1 && (CNT_W'(ridx_s1) == count_q - CNT_W'(1));

	// Sequencer: next state, memory port control and result strobes.
	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = sender_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			gmtf_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (count_q == '0) ? gmtf_pkg::ST_FIN : gmtf_pkg::ST_SCAN;
				end
			end
			gmtf_pkg::ST_SCAN: begin
				issue = (iss_q < count_q);
				// A new receiver pushes out the one held back.
				emit = take && pend_vld_q;
				// After the leaving ID, each entry moves one place down.
				if (op_q == gmtf_pkg::OP_LEAVE && found_q && rvld_s1) begin
					we    = 1'b1;
					waddr = ridx_s1 - IDX_W'(1);
					wdata = rd_s1;
				end
				if (scan_end) begin
					state_d = gmtf_pkg::ST_FIN;
				end
			end
			gmtf_pkg::ST_FIN: begin
				state_d = gmtf_pkg::ST_IDLE;
				if (op_q == gmtf_pkg::OP_MSG) begin
					emit      = pend_vld_q;
					emit_last = 1'b1;
					// Append an absent sender when there is room.
					if (!found_q && count_q < CNT_W'(CAPACITY)) begin
						we    = 1'b1;
						waddr = count_q[IDX_W-1:0];
						wdata = sender_q;
					end
				end
			end
			default: begin
				state_d = gmtf_pkg::ST_IDLE;
			end
		endcase
	end

	// Member table memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_s1 <= mem[iss_q[IDX_W-1:0]];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gmtf_pkg::ST_IDLE;
			count_q    <= '0;
			iss_q      <= '0;
			rvld_s1    <= 1'b0;
			found_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			ncol_q     <= '0;
			valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= issue;
			valid_q <= emit;
			if (issue) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (accept) begin
				iss_q      <= '0;
				found_q    <= 1'b0;
				pend_vld_q <= 1'b0;
				ncol_q     <= '0;
			end
			if (state_q == gmtf_pkg::ST_SCAN) begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (take) begin
					pend_vld_q <= 1'b1;
					ncol_q     <= ncol_q + CNT_W'(1);
				end
			end
			if (state_q == gmtf_pkg::ST_FIN) begin
				if (op_q == gmtf_pkg::OP_MSG && !found_q && count_q < CNT_W'(CAPACITY)) begin
					count_q <= count_q + CNT_W'(1);
				end else if (op_q == gmtf_pkg::OP_LEAVE && found_q) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// Item fields, read index and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			sender_q  <= sender_id;
			payload_q <= payload_handle;
		end
		if (issue) begin
			ridx_s1 <= iss_q[IDX_W-1:0];
		end
		if (state_q == gmtf_pkg::ST_SCAN && take) begin
			pend_q <= rd_s1;
		end
		if (emit) begin
			recv_q <= pend_q;
			last_q <= emit_last;
		end
	end

	assign busy        = (state_q != gmtf_pkg::ST_IDLE);
	assign valid       = valid_q;
	assign receiver_id = recv_q;
	assign origin_id   = sender_q;
	assign payload_out = payload_q;
	assign last        = last_q;

endmodule

@@ hdl/gmtf_checker.sv @@
module gmtf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic operation,
	input logic valid,
	input logic last
);

	// An accepted item always raises busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after an accepted item");

	// A leave item never produces a result right after acceptance.
	a_leave_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == gmtf_pkg::OP_LEAVE) |=> !valid)
		else $error("result seen after a leave item");

	// The final copy of a message is followed by a gap.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("result directly after the final copy");

	// A copy that is not the final one only appears while the item is in work.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final copy seen while idle");

endmodule

bind group_member_table_fanout gmtf_checker u_gmtf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.valid     (valid),
	.last      (last)
);

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int TABLE_DEPTH    = gmtf_pkg::CAPACITY_DEF;
	localparam int MAX_COPIES     = TABLE_DEPTH - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;
	localparam int ID_POOL_SIZE   = 42;
	localparam int RANDOM_ITEMS   = 210;

	typedef logic [gmtf_pkg::ID_W-1:0] id_t;

	// One forwarded copy of a message as the block should emit it.
	typedef struct {
		id_t  receiver;
		id_t  origin;
		id_t  payload;
		logic last;
	} fanout_copy_t;

	logic clk            = 1'b0;
	logic arst_n         = 1'b0;
	logic start          = 1'b0;
	logic operation      = gmtf_pkg::OP_MSG;
	id_t  sender_id      = '0;
	id_t  payload_handle = '0;

	logic busy;
	logic valid;
	id_t  receiver_id;
	id_t  origin_id;
	id_t  payload_out;
	logic last;

	// Predicted member table and the copies still owed by the block.
	id_t          roster[$];
	fanout_copy_t pending_copies[$];

	int err_cnt         = 0;
	int items_sent      = 0;
	int leaves_sent     = 0;
	int copies_seen     = 0;
	int full_skips      = 0;
	int peak_members    = 0;
	int burst_left      = 0;
	int idle_cycles     = 0;

	group_member_table_fanout #(
		.CAPACITY(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.sender_id(sender_id),
		.payload_handle(payload_handle),
		.valid(valid),
		.receiver_id(receiver_id),
		.origin_id(origin_id),
		.payload_out(payload_out),
		.last(last)
	);

	always #CLK_HALF clk = ~clk;

	// Position of an ID in the predicted table, or -1 if it is not listed.
	function automatic int find_member(input id_t id);
		int pos;
		pos = -1;
		foreach (roster[i])
			if (pos < 0 && roster[i] == id)
				pos = i;
		return pos;
	endfunction

	// Update the predicted table for one item and queue the copies it causes.
	function automatic void predict_fanout(input logic op, input id_t sid, input id_t pay);
		int pos;
		int copies;
		fanout_copy_t c;
		pos = find_member(sid);
		if (op == gmtf_pkg::OP_LEAVE) begin
			if (pos >= 0)
				roster.delete(pos);
		end else begin
			if (pos < 0 && roster.size() < TABLE_DEPTH)
				roster.push_back(sid);
			else if (pos < 0)
				full_skips++;
			if (roster.size() > peak_members)
				peak_members = roster.size();
			copies = 0;
			foreach (roster[i]) begin
				if (roster[i] != sid && copies < MAX_COPIES) begin
					c.receiver = roster[i];
					c.origin   = sid;
					c.payload  = pay;
					c.last     = 1'b0;
					pending_copies.push_back(c);
					copies++;
				end
			end
			if (copies > 0)
				pending_copies[pending_copies.size() - 1].last = 1'b1;
		end
	endfunction

	// Sender idling: bursts of random length separated by random gaps.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(20, 45)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(10, 40);
			else
				burst_left = $urandom_range(0, 6);
		end
	endtask

	// Present one item and hold it until the block takes it.
	task automatic send_item(input logic op, input id_t sid, input id_t pay);
		start          <= 1'b1;
		operation      <= op;
		sender_id      <= sid;
		payload_handle <= pay;
		do @(posedge clk); while (busy);
		predict_fanout(op, sid, pay);
		items_sent++;
		if (op == gmtf_pkg::OP_LEAVE)
			leaves_sent++;
		pace_sender();
	endtask

	// Hold off the sender until every predicted copy has been seen.
	task automatic wait_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_copies.size() != 0 || busy);
	endtask

	// Extreme IDs and payloads, joins, leaves from head, middle and tail, absent leaves.
	task automatic test_basic_ops();
		send_item(gmtf_pkg::OP_MSG, 16'h0000, 16'h0000);
		send_item(gmtf_pkg::OP_MSG, 16'hFFFF, 16'hFFFF);
		send_item(gmtf_pkg::OP_MSG, 16'h0000, 16'h1234);
		send_item(gmtf_pkg::OP_LEAVE, 16'h5A5A, 16'hFFFF);
		send_item(gmtf_pkg::OP_MSG, 16'hA5A5, 16'h5A5A);
		send_item(gmtf_pkg::OP_MSG, 16'h5A5A, 16'hA5A5);
		send_item(gmtf_pkg::OP_LEAVE, 16'hFFFF, 16'h0000);
		send_item(gmtf_pkg::OP_MSG, 16'hA5A5, 16'hFFFF);
		send_item(gmtf_pkg::OP_LEAVE, 16'h5A5A, 16'h0001);
		send_item(gmtf_pkg::OP_MSG, 16'h0000, 16'h8000);
		send_item(gmtf_pkg::OP_LEAVE, 16'h0000, 16'h0000);
		send_item(gmtf_pkg::OP_LEAVE, 16'hA5A5, 16'h0000);
		send_item(gmtf_pkg::OP_MSG, 16'h1111, 16'h7FFF);
		send_item(gmtf_pkg::OP_LEAVE, 16'h1111, 16'h0000);
		send_item(gmtf_pkg::OP_LEAVE, 16'h1111, 16'hFFFF);
		send_item(gmtf_pkg::OP_MSG, 16'hFFFF, 16'h0000);
		send_item(gmtf_pkg::OP_LEAVE, 16'hFFFF, 16'h0000);
	endtask

	// Fill the table, then send from an outsider so the copy count hits its cap.
	task automatic test_full_table();
		id_t outsider;
		while (roster.size() < TABLE_DEPTH)
			send_item(gmtf_pkg::OP_MSG, id_t'($urandom), id_t'($urandom));
		do outsider = id_t'($urandom); while (find_member(outsider) >= 0);
		send_item(gmtf_pkg::OP_MSG, outsider, 16'hFFFF);
		send_item(gmtf_pkg::OP_MSG, roster[TABLE_DEPTH - 1], 16'h0000);
		send_item(gmtf_pkg::OP_MSG, roster[0], 16'hC3C3);
		send_item(gmtf_pkg::OP_LEAVE, roster[TABLE_DEPTH / 2], 16'h0000);
		send_item(gmtf_pkg::OP_MSG, outsider, 16'h3C3C);
		send_item(gmtf_pkg::OP_LEAVE, outsider, 16'h0000);
		// Empty the table again in random order.
		while (roster.size() > 0)
			send_item(gmtf_pkg::OP_LEAVE, roster[$urandom_range(0, roster.size() - 1)],
				id_t'($urandom));
	endtask

	// Mixed traffic over a small ID pool so the table fills and drains repeatedly.
	task automatic test_random_traffic(input int n_items);
		id_t  id_pool[ID_POOL_SIZE];
		id_t  sid;
		logic op;
		int   leave_pct;
		int   phase_left;
		foreach (id_pool[i])
			id_pool[i] = id_t'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;
		leave_pct  = 10;
		phase_left = 0;
		for (int k = 0; k < n_items; k++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0: leave_pct = 8;
					1: leave_pct = 40;
					default: leave_pct = 75;
				endcase
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			if ($urandom_range(0, 9) == 0)
				sid = id_t'($urandom);
			else
				sid = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
			op = ($urandom_range(0, 99) < leave_pct) ? gmtf_pkg::OP_LEAVE : gmtf_pkg::OP_MSG;
			if (k == n_items / 2)
				wait_until_drained();
			send_item(op, sid, id_t'($urandom));
		end
	endtask

	// Compare every emitted copy with the oldest predicted one.
	always @(posedge clk) begin
		fanout_copy_t want;
		if (arst_n && valid) begin
			copies_seen++;
			if (pending_copies.size() == 0) begin
				$error("Unexpected result: receiver_id=%h origin_id=%h payload_out=%h last=%b",
					receiver_id, origin_id, payload_out, last);
				err_cnt++;
			end else begin
				want = pending_copies.pop_front();
				if (receiver_id !== want.receiver) begin
					$error("receiver_id: expected %h, actual %h", want.receiver, receiver_id);
					err_cnt++;
				end
				if (origin_id !== want.origin) begin
					$error("origin_id: expected %h, actual %h", want.origin, origin_id);
					err_cnt++;
				end
				if (payload_out !== want.payload) begin
					$error("payload_out: expected %h, actual %h", want.payload, payload_out);
					err_cnt++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, actual %b", want.last, last);
					err_cnt++;
				end
			end
		end
	end

	// End the run if neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item or result for %0d cycles, %0d results outstanding",
				idle_cycles, pending_copies.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		wait_until_drained();
		test_full_table();
		wait_until_drained();
		test_random_traffic(RANDOM_ITEMS);
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items (%0d leaves) and checked %0d forwarded copies.",
			items_sent, leaves_sent, copies_seen);
		$display("Table peaked at %0d members; %0d joins were skipped on a full table.",
			peak_members, full_skips);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
